/* sv/button_debounce_click_classifier_defines.svh */
// Assertion macros for the button qualifier.
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_DEFINES_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_DEFINES_SVH

// Same-cycle implication.
`define BDCC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdcc: same-cycle check failed");

// Next-cycle implication.
`define BDCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdcc: next-cycle check failed");

`endif

/* sv/bdcc_pkg.sv */
package bdcc_pkg;

   localparam int LEVEL_W   = 5;
   localparam int NOW_W     = 32;
   localparam int INDEX_W   = 3;
   localparam int EVENT_W   = 2;
   localparam int DEB_W     = 4;
   localparam int THRESH_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [DEB_W-1:0]    DEBOUNCE_POLLS_RESET = 4'd3;
   localparam logic [THRESH_W-1:0] HOLD_MS_RESET        = 16'd500;
   localparam logic [THRESH_W-1:0] RELEASE_MS_RESET     = 16'd150;
   localparam logic [LEVEL_W-1:0]  IDLE_LEVELS_RESET    = 5'd4;

   localparam logic [EVENT_W-1:0]  EVENT_NONE = 2'd0;

   typedef enum logic {
      REQ_POLL  = 1'b0,
      REQ_CHECK = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE_POLLS = 2'd0,
      CSR_HOLD_MS        = 2'd1,
      CSR_RELEASE_MS     = 2'd2,
      CSR_IDLE_LEVELS    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      CLICK_RELEASED   = 3'd0,
      CLICK_PUSHED     = 3'd1,
      CLICK_DOUBLE     = 3'd2,
      CLICK_HELD       = 3'd3,
      CLICK_WAIT_PRESS = 3'd4,
      CLICK_WAIT_AGAIN = 3'd5
   } click_state_type;

endpackage

/* sv/bdcc_if.sv */
interface bdcc_req_if;
   logic                            valid;
   logic                            ready;
   logic                            req_type;
   logic [bdcc_pkg::LEVEL_W-1:0]    raw_levels;
   logic [bdcc_pkg::NOW_W-1:0]      now_ms;
   logic [bdcc_pkg::INDEX_W-1:0]    button_index;

   modport source (output valid, req_type, raw_levels, now_ms, button_index, input ready);
   modport sink (input valid, req_type, raw_levels, now_ms, button_index, output ready);
endinterface

interface bdcc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bdcc_pkg::EVENT_W-1:0]    event_code;
   logic [bdcc_pkg::LEVEL_W-1:0]    debounced_levels;

   modport source (output valid, event_code, debounced_levels, input ready);
   modport sink (input valid, event_code, debounced_levels, output ready);
endinterface

/* sv/button_debounce_click_classifier.sv */
// Button debouncer and click classifier.
// req channel: a poll word (req_type 0) carries raw pin levels and the
//   millisecond tick; a check word (req_type 1) names one button and
//   consumes its pending event (pushed, double or held).
// rsp channel: exactly one word per request: event_code (always 0 for a
//   poll) and the debounced levels after the request.
// csr port: write enable, index and data; write only while the block is idle.
// Pipeline: a word accepted on req is captured in the input register,
//   processed by the compute stage and shown on rsp from the output register.
//   Throughput is one word per cycle while rsp is not stalled, set by the single
//   compute stage between the input and output registers.
// Reset (synchronous, active high) restores the register defaults, sets
//   every button released at its reset idle level and empties both stages.
// A stalled rsp holds its word; the input register keeps taking one more
//   word, then req.ready drops until the output moves.
`include "button_debounce_click_classifier_defines.svh"

module button_debounce_click_classifier #(
   parameter int BUTTON_COUNT = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   bdcc_req_if.sink                              req,
   bdcc_rsp_if.source                            rsp,
   input  logic                                  csr_wr_en,
   input  logic [bdcc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bdcc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int LW = bdcc_pkg::LEVEL_W;

   logic [bdcc_pkg::DEB_W-1:0]    debounce_polls_ff;
   logic [bdcc_pkg::THRESH_W-1:0] hold_ms_ff;
   logic [bdcc_pkg::THRESH_W-1:0] release_ms_ff;
   logic [LW-1:0]                 idle_levels_ff;

   logic                          in_valid_ff;
   logic                          in_type_ff;
   logic [LW-1:0]                 in_raw_ff;
   logic [bdcc_pkg::NOW_W-1:0]    in_now_ff;
   logic [bdcc_pkg::INDEX_W-1:0]  in_idx_ff;

   logic                          out_valid_ff;
   logic [bdcc_pkg::EVENT_W-1:0]  event_ff, event_in;
   logic [LW-1:0]                 levels_ff, levels_in, levels_now;

   logic [BUTTON_COUNT-1:0]       confirmed_ff, confirmed_in;
   logic [BUTTON_COUNT-1:0]       change_ff, change_in;
   logic [bdcc_pkg::DEB_W-1:0]    differ_ff [BUTTON_COUNT];
   logic [bdcc_pkg::DEB_W-1:0]    differ_in [BUTTON_COUNT];
   bdcc_pkg::click_state_type     state_ff [BUTTON_COUNT];
   bdcc_pkg::click_state_type     state_in [BUTTON_COUNT];
   logic [bdcc_pkg::NOW_W-1:0]    mark_ff [BUTTON_COUNT];
   logic [bdcc_pkg::NOW_W-1:0]    mark_in [BUTTON_COUNT];

   logic [BUTTON_COUNT-1:0]       raw_bit, idle_bit, reset_level;
   logic                          advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign rsp.valid = out_valid_ff;
   assign rsp.event_code = event_ff;
   assign rsp.debounced_levels = levels_ff;

   for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_btn
      if (g < LW) begin : g_pin
         assign raw_bit[g]     = in_raw_ff[g];
         assign idle_bit[g]    = idle_levels_ff[g];
         assign reset_level[g] = bdcc_pkg::IDLE_LEVELS_RESET[g];
      end else begin : g_nopin
         assign raw_bit[g]     = 1'b0;
         assign idle_bit[g]    = 1'b0;
         assign reset_level[g] = 1'b0;
      end
   end

   for (genvar g = 0; g < LW; g++) begin : g_lvl
      if (g < BUTTON_COUNT) begin : g_used
         assign levels_in[g]  = confirmed_in[g];
         assign levels_now[g] = confirmed_ff[g];
      end else begin : g_unused
         assign levels_in[g]  = 1'b0;
         assign levels_now[g] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_polls_ff <= bdcc_pkg::DEBOUNCE_POLLS_RESET;
         hold_ms_ff        <= bdcc_pkg::HOLD_MS_RESET;
         release_ms_ff     <= bdcc_pkg::RELEASE_MS_RESET;
         idle_levels_ff    <= bdcc_pkg::IDLE_LEVELS_RESET;
      end else if (csr_wr_en) begin
         unique case (bdcc_pkg::csr_index_type'(csr_index))
            bdcc_pkg::CSR_DEBOUNCE_POLLS: debounce_polls_ff <= csr_wdata[bdcc_pkg::DEB_W-1:0];
            bdcc_pkg::CSR_HOLD_MS:        hold_ms_ff        <= csr_wdata;
            bdcc_pkg::CSR_RELEASE_MS:     release_ms_ff     <= csr_wdata;
            bdcc_pkg::CSR_IDLE_LEVELS:    idle_levels_ff    <= csr_wdata[LW-1:0];
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_type_ff <= req.req_type;
         in_raw_ff  <= req.raw_levels;
         in_now_ff  <= req.now_ms;
         in_idx_ff  <= req.button_index;
      end
   end

   // output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         event_ff  <= event_in;
         levels_ff <= levels_in;
      end
   end

   // per-button state
   always_ff @(posedge clock) begin
      if (reset) begin
         confirmed_ff <= reset_level;
         change_ff    <= '0;
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            differ_ff[i] <= '0;
            state_ff[i]  <= bdcc_pkg::CLICK_RELEASED;
         end
      end else begin
         confirmed_ff <= confirmed_in;
         change_ff    <= change_in;
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            differ_ff[i] <= differ_in[i];
            state_ff[i]  <= state_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
         mark_ff[i] <= mark_in[i];
      end
   end

   always_comb begin
      logic [bdcc_pkg::DEB_W-1:0] cnt;
      logic                       lvl;
      logic                       chg;
      logic [bdcc_pkg::NOW_W-1:0] elapsed;
      logic                       pending;
      confirmed_in = confirmed_ff;
      change_in    = change_ff;
      event_in     = bdcc_pkg::EVENT_NONE;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
         differ_in[i] = differ_ff[i];
         state_in[i]  = state_ff[i];
         mark_in[i]   = mark_ff[i];
         cnt          = differ_ff[i] + 4'd1;
         lvl          = confirmed_ff[i];
         chg          = change_ff[i];
         elapsed      = in_now_ff - mark_ff[i];
         pending      = (state_ff[i] == bdcc_pkg::CLICK_PUSHED) ||
                        (state_ff[i] == bdcc_pkg::CLICK_DOUBLE) ||
                        (state_ff[i] == bdcc_pkg::CLICK_HELD);
         if (advance && (in_type_ff == bdcc_pkg::REQ_POLL)) begin
            if (raw_bit[i] != confirmed_ff[i]) begin
               if (cnt >= debounce_polls_ff) begin
                  lvl          = raw_bit[i];
                  chg          = 1'b1;
                  differ_in[i] = '0;
               end else begin
                  differ_in[i] = cnt;
               end
            end else begin
               differ_in[i] = '0;
            end
            unique case (state_ff[i])
               bdcc_pkg::CLICK_RELEASED: begin
                  if (chg && (lvl != idle_bit[i])) begin
                     state_in[i] = bdcc_pkg::CLICK_WAIT_PRESS;
                     mark_in[i]  = in_now_ff;
                     chg         = 1'b0;
                  end
               end
               bdcc_pkg::CLICK_WAIT_PRESS: begin
                  if (lvl == idle_bit[i]) begin
                     state_in[i] = bdcc_pkg::CLICK_WAIT_AGAIN;
                     mark_in[i]  = in_now_ff;
                     chg         = 1'b0;
                  end else if (elapsed > {16'd0, hold_ms_ff}) begin
                     state_in[i] = bdcc_pkg::CLICK_HELD;
                  end
               end
               bdcc_pkg::CLICK_WAIT_AGAIN: begin
                  if (lvl != idle_bit[i]) begin
                     state_in[i] = bdcc_pkg::CLICK_DOUBLE;
                     chg         = 1'b0;
                  end else if (elapsed > {16'd0, release_ms_ff}) begin
                     state_in[i] = bdcc_pkg::CLICK_PUSHED;
                  end
               end
               default: ;
            endcase
            confirmed_in[i] = lvl;
            change_in[i]    = chg;
         end else if (advance && (in_type_ff == bdcc_pkg::REQ_CHECK) &&
                      (32'(in_idx_ff) == i) && pending) begin
            event_in     = state_ff[i][bdcc_pkg::EVENT_W-1:0];
            state_in[i]  = bdcc_pkg::CLICK_RELEASED;
            change_in[i] = 1'b0;
         end
      end
   end

   `BDCC_ASSERT_NEXT(a_poll_no_event, clock, reset,
      advance && (in_type_ff == bdcc_pkg::REQ_POLL), rsp.event_code == bdcc_pkg::EVENT_NONE)
   `BDCC_ASSERT_NEXT(a_check_range, clock, reset,
      advance && (in_type_ff == bdcc_pkg::REQ_CHECK) && (32'(in_idx_ff) >= BUTTON_COUNT),
      rsp.event_code == bdcc_pkg::EVENT_NONE)
   `BDCC_ASSERT_NOW(a_full_blocks, clock, reset, in_valid_ff && !advance, !req.ready)
   `BDCC_ASSERT_NEXT(a_levels_track, clock, reset, advance, rsp.debounced_levels == levels_now)

endmodule

/* tb/button_debounce_click_classifier_test.sv */
module button_debounce_click_classifier_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bdcc_pkg::*;

   localparam int PERIOD    = 10;
   localparam int BUTTONS   = 5;
   localparam int HOLD_SPAN = 300;
   localparam int PHASES    = 8;
   localparam int PER_PHASE = 50;
   localparam int PLAN_ROWS = 27;

   typedef enum {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_type;
   typedef enum {ROW_POLL, ROW_CHECK, ROW_WRITE} plan_op_type;

   typedef struct {
      logic [EVENT_W-1:0] ev;
      logic [LEVEL_W-1:0] lv;
   } outcome_type;

   typedef struct {
      plan_op_type        op;
      csr_index_type      sel;
      logic [LEVEL_W-1:0] raw;
      logic [31:0]        arg;
      logic               typed;
      logic [EVENT_W-1:0] ev;
      logic [LEVEL_W-1:0] lv;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bdcc_req_if req_ch ();
   bdcc_rsp_if rsp_ch ();

   button_debounce_click_classifier DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(PERIOD / 2) clock = ~clock;

   // predictor copy of the block
   logic [DEB_W-1:0]    deb_polls;
   logic [THRESH_W-1:0] hold_ms;
   logic [THRESH_W-1:0] release_ms;
   logic [LEVEL_W-1:0]  idle_lv;
   logic                pin_level   [BUTTONS];
   logic [DEB_W-1:0]    streak      [BUTTONS];
   logic                change_seen [BUTTONS];
   click_state_type     click       [BUTTONS];
   logic [NOW_W-1:0]    press_mark  [BUTTONS];

   outcome_type awaited [$];
   pace_type    pace = PACE_FREE;
   bit          hold_req = 1'b0;
   int          stall_left = 0;
   int          mismatches = 0;
   int          words_seen = 0;
   int          polls_sent = 0;
   int          checks_sent = 0;
   int          settings_used = 0;
   int          tally [4];

   int deb_choice  [PHASES] = '{1, 0, 15, 2, 5, 3, 1, 8};
   int hold_choice [PHASES] = '{500, 0, 65535, 40, 1000, 20, 100, 65535};
   int rel_choice  [PHASES] = '{150, 65535, 0, 30, 300, 10, 60, 0};

   plan_row_type plan [PLAN_ROWS];

   function automatic void classify_word(input req_kind_type kind,
         input logic [LEVEL_W-1:0] raw, input logic [NOW_W-1:0] now,
         input logic [INDEX_W-1:0] idx, output logic [EVENT_W-1:0] ev,
         output logic [LEVEL_W-1:0] lv);
      logic [NOW_W-1:0] span;
      logic             rest;
      ev = EVENT_NONE;
      if (kind == REQ_POLL) begin
         for (int b = 0; b < BUTTONS; b++) begin
            rest = idle_lv[b];
            if (raw[b] != pin_level[b]) begin
               streak[b] = streak[b] + 1'b1;
               if (streak[b] >= deb_polls) begin
                  pin_level[b]   = raw[b];
                  change_seen[b] = 1'b1;
                  streak[b]      = '0;
               end
            end else begin
               streak[b] = '0;
            end
            span = now - press_mark[b];
            case (click[b])
               CLICK_RELEASED: begin
                  if (change_seen[b] && pin_level[b] != rest) begin
                     click[b]       = CLICK_WAIT_PRESS;
                     press_mark[b]  = now;
                     change_seen[b] = 1'b0;
                  end
               end
               CLICK_WAIT_PRESS: begin
                  if (pin_level[b] == rest) begin
                     click[b]       = CLICK_WAIT_AGAIN;
                     press_mark[b]  = now;
                     change_seen[b] = 1'b0;
                  end else if (span > hold_ms) begin
                     click[b] = CLICK_HELD;
                  end
               end
               CLICK_WAIT_AGAIN: begin
                  if (pin_level[b] != rest) begin
                     click[b]       = CLICK_DOUBLE;
                     change_seen[b] = 1'b0;
                  end else if (span > release_ms) begin
                     click[b] = CLICK_PUSHED;
                  end
               end
               default: ;
            endcase
         end
      end else if (idx < BUTTONS) begin
         if (click[idx] == CLICK_PUSHED || click[idx] == CLICK_DOUBLE ||
               click[idx] == CLICK_HELD) begin
            ev = EVENT_W'(click[idx]);
            change_seen[idx] = 1'b0;
            click[idx]       = CLICK_RELEASED;
         end
      end
      for (int b = 0; b < BUTTONS; b++) lv[b] = pin_level[b];
   endfunction

   task automatic send_word(input req_kind_type kind, input logic [LEVEL_W-1:0] raw,
         input logic [NOW_W-1:0] now, input logic [INDEX_W-1:0] idx,
         input logic typed, input logic [EVENT_W-1:0] typed_ev,
         input logic [LEVEL_W-1:0] typed_lv);
      outcome_type want;
      while ($urandom_range(99) <
             ((pace == PACE_SENDER) ? 82 : (pace == PACE_BOTH) ? 7 : 0)) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= kind;
      req_ch.raw_levels   <= raw;
      req_ch.now_ms       <= now;
      req_ch.button_index <= idx;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      classify_word(kind, raw, now, idx, want.ev, want.lv);
      if (typed) begin
         want.ev = typed_ev;
         want.lv = typed_lv;
      end
      awaited.push_back(want);
      if (kind == REQ_POLL) polls_sent++;
      else checks_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type sel, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (sel)
         CSR_DEBOUNCE_POLLS: deb_polls  = value[DEB_W-1:0];
         CSR_HOLD_MS:        hold_ms    = value;
         CSR_RELEASE_MS:     release_ms = value;
         CSR_IDLE_LEVELS:    idle_lv    = value[LEVEL_W-1:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : collect
      outcome_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         words_seen++;
         if (!$isunknown(rsp_ch.event_code)) tally[rsp_ch.event_code]++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: event %0d levels %b",
                        rsp_ch.event_code, rsp_ch.debounced_levels);
         end else begin
            want = awaited.pop_front();
            if (rsp_ch.event_code !== want.ev ||
                  rsp_ch.debounced_levels !== want.lv) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word %0d: expected event %0d levels %b, got event %0d levels %b",
                           words_seen, want.ev, want.lv,
                           rsp_ch.event_code, rsp_ch.debounced_levels);
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (hold_req) begin
         hold_req   = 1'b0;
         stall_left = HOLD_SPAN;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >=
            ((pace == PACE_RECEIVER) ? 82 : (pace == PACE_BOTH) ? 7 : 0));
      end
   end

   initial begin
      #2ms;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int                 run_left;
      int                 span;
      int                 thr;
      int                 step;
      logic [LEVEL_W-1:0] target;
      logic [LEVEL_W-1:0] raw;
      logic [NOW_W-1:0]   clock_ms;
      logic [DEB_W-1:0]   deb_v;
      logic [THRESH_W-1:0] hold_v;
      logic [THRESH_W-1:0] rel_v;
      logic [LEVEL_W-1:0] idle_v;

      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = CSR_DEBOUNCE_POLLS;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = REQ_POLL;
      req_ch.raw_levels   = '0;
      req_ch.now_ms       = '0;
      req_ch.button_index = '0;
      rsp_ch.ready        = 1'b0;

      deb_polls  = DEBOUNCE_POLLS_RESET;
      hold_ms    = HOLD_MS_RESET;
      release_ms = RELEASE_MS_RESET;
      idle_lv    = IDLE_LEVELS_RESET;
      for (int b = 0; b < BUTTONS; b++) begin
         pin_level[b]   = idle_lv[b];
         streak[b]      = '0;
         change_seen[b] = 1'b0;
         click[b]       = CLICK_RELEASED;
         press_mark[b]  = '0;
      end

      plan = '{
         '{ROW_CHECK, CSR_DEBOUNCE_POLLS, 5'h00, 32'd0, 1'b1, EVENT_NONE, 5'h04},
         '{ROW_CHECK, CSR_DEBOUNCE_POLLS, 5'h00, 32'd7, 1'b1, EVENT_NONE, 5'h04},
         '{ROW_CHECK, CSR_DEBOUNCE_POLLS, 5'h00, 32'd5, 1'b1, EVENT_NONE, 5'h04},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h1b, 32'h0, 1'b1, EVENT_NONE, 5'h04},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h04, 32'hffff_ffff, 1'b1, EVENT_NONE, 5'h04},
         '{ROW_WRITE, CSR_DEBOUNCE_POLLS, 5'h00, 32'd0, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h05, 32'hffff_fff0, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h05, 32'h100, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h05, 32'h300, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_CHECK, CSR_DEBOUNCE_POLLS, 5'h00, 32'd0, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_CHECK, CSR_DEBOUNCE_POLLS, 5'h00, 32'd0, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h04, 32'h400, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h05, 32'h410, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h04, 32'h420, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h05, 32'h430, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_CHECK, CSR_DEBOUNCE_POLLS, 5'h00, 32'd0, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h04, 32'h440, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h05, 32'h450, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h04, 32'h460, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h04, 32'h4f6, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h04, 32'h4f7, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h05, 32'h500, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_CHECK, CSR_DEBOUNCE_POLLS, 5'h00, 32'd0, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_WRITE, CSR_IDLE_LEVELS, 5'h00, 32'h1f, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h1f, 32'h0, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_POLL, CSR_DEBOUNCE_POLLS, 5'h00, 32'hffff_ffff, 1'b0, EVENT_NONE, 5'h00},
         '{ROW_CHECK, CSR_DEBOUNCE_POLLS, 5'h00, 32'd4, 1'b0, EVENT_NONE, 5'h00}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[r]) begin
         case (plan[r].op)
            ROW_WRITE: begin
               drain();
               write_reg(plan[r].sel, plan[r].arg[CSR_DATA_W-1:0]);
               settings_used++;
            end
            ROW_POLL:
               send_word(REQ_POLL, plan[r].raw, plan[r].arg, '0,
                         plan[r].typed, plan[r].ev, plan[r].lv);
            default:
               send_word(REQ_CHECK, '0, '0, plan[r].arg[INDEX_W-1:0],
                         plan[r].typed, plan[r].ev, plan[r].lv);
         endcase
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         deb_v  = DEB_W'(deb_choice[p]);
         hold_v = THRESH_W'(hold_choice[p]);
         rel_v  = THRESH_W'(rel_choice[p]);
         idle_v = (p == 1) ? 5'h00 : (p == 2) ? 5'h1f : LEVEL_W'($urandom_range(0, 31));
         write_reg(CSR_DEBOUNCE_POLLS, CSR_DATA_W'(deb_v));
         write_reg(CSR_HOLD_MS, hold_v);
         write_reg(CSR_RELEASE_MS, rel_v);
         write_reg(CSR_IDLE_LEVELS, CSR_DATA_W'(idle_v));
         settings_used++;
         pace     = pace_type'(p % 4);
         span     = (deb_v == 0) ? 1 : int'(deb_v);
         thr      = (hold_v > rel_v) ? int'(hold_v) : int'(rel_v);
         target   = idle_v;
         run_left = span;
         clock_ms = (p == 3) ? 32'hffff_ffc0 : $urandom();
         for (int n = 0; n < PER_PHASE; n++) begin
            // starve the output so the block backs up onto its input
            if (p == 4 && n == 10) hold_req = 1'b1;
            if ($urandom_range(99) < 25) begin
               send_word(REQ_CHECK, '0, '0,
                         ($urandom_range(9) == 0) ? INDEX_W'($urandom_range(5, 7))
                                                  : INDEX_W'($urandom_range(0, 4)),
                         1'b0, EVENT_NONE, '0);
            end else begin
               if (run_left == 0) begin
                  if ($urandom_range(99) < 15) target ^= LEVEL_W'($urandom_range(1, 31));
                  else target ^= LEVEL_W'(1 << $urandom_range(0, 4));
                  run_left = ($urandom_range(99) < 20) ? $urandom_range(1, span)
                                                       : $urandom_range(span, span + 4);
               end
               run_left--;
               raw = target;
               if ($urandom_range(99) < 8) raw ^= LEVEL_W'(1 << $urandom_range(0, 4));
               step = $urandom_range(99);
               if (step < 50) clock_ms += $urandom_range(0, 15);
               else if (step < 80) clock_ms += $urandom_range(0, thr + 1);
               else clock_ms += $urandom_range(0, 2 * thr + 2);
               send_word(REQ_POLL, raw, clock_ms, INDEX_W'($urandom_range(0, 7)),
                         1'b0, EVENT_NONE, '0);
            end
         end
      end

      drain();
      repeat (10) @(posedge clock);
      $display("%0d words (%0d polls, %0d checks) over %0d register settings",
               words_seen, polls_sent, checks_sent, settings_used);
      $display("checks returned %0d pushes, %0d doubles, %0d holds; %0d mismatches",
               tally[1], tally[2], tally[3], mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/bdcc_pkg.sv
sv/bdcc_if.sv
sv/button_debounce_click_classifier.sv
tb/button_debounce_click_classifier_test.sv
